FILE: hw/rtl/iirdf_pkg.sv
`default_nettype none

package iirdf_pkg;

  localparam int unsigned TAPS       = 4;
  localparam int unsigned HIST_DEPTH = 3;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned YHIST_W    = 40;
  localparam int unsigned YLO_W      = 16;
  localparam int unsigned OPND_W     = SAMPLE_W + 1;
  localparam int unsigned PROD_W     = COEF_W + OPND_W;
  localparam int unsigned ACC_W      = 54;
  localparam int unsigned TMP_W      = 64;
  localparam int unsigned PC_W       = 4;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  typedef enum logic [2:0] {
    REG_B0       = 3'd0,
    REG_B1       = 3'd1,
    REG_B2       = 3'd2,
    REG_B3       = 3'd3,
    REG_A1       = 3'd4,
    REG_A2       = 3'd5,
    REG_A3       = 3'd6,
    REG_FEEDBACK = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_B3 = 3'd3,
    COEF_A1 = 3'd4,
    COEF_A2 = 3'd5,
    COEF_A3 = 3'd6
  } coef_e;

  typedef enum logic [3:0] {
    SRC_X   = 4'd0,
    SRC_X1  = 4'd1,
    SRC_X2  = 4'd2,
    SRC_X3  = 4'd3,
    SRC_Y1L = 4'd4,
    SRC_Y1H = 4'd5,
    SRC_Y2L = 4'd6,
    SRC_Y2H = 4'd7,
    SRC_Y3L = 4'd8,
    SRC_Y3H = 4'd9
  } src_e;

  typedef enum logic [1:0] {
    ACC_NOP  = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_e;

  typedef enum logic [1:0] {
    TMP_NOP    = 2'd0,
    TMP_LOAD   = 2'd1,
    TMP_ADD_HI = 2'd2
  } tmp_e;

  typedef enum logic [1:0] {
    SEQ_NEXT    = 2'd0,
    SEQ_SKIP_FB = 2'd1,
    SEQ_FINISH  = 2'd2
  } seq_e;

  typedef struct packed {
    coef_e            coef;
    src_e             src;
    acc_e             acc;
    tmp_e             tmp;
    seq_e             seq;
    logic [PC_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic load;
    logic run;
    logic commit;
    ucw_t uw;
  } ctrl_t;

  typedef struct packed {
    logic [TAPS-1:0][COEF_W-1:0]       b;
    logic [HIST_DEPTH-1:0][COEF_W-1:0] a;
    logic                              fb_on;
  } cfg_t;

  localparam logic [PC_W-1:0] PC_FINISH = PC_W'(12);
  localparam logic [PC_W-1:0] PC_LAST   = PC_FINISH;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{coef: COEF_B0, src: SRC_X, acc: ACC_NOP, tmp: TMP_NOP,
          seq: SEQ_NEXT, target: '0};
    case (pc)
      PC_W'(0): begin
        w.coef = COEF_B0; w.src = SRC_X;
      end
      PC_W'(1): begin
        w.coef = COEF_B1; w.src = SRC_X1; w.acc = ACC_LOAD;
      end
      PC_W'(2): begin
        w.coef = COEF_B2; w.src = SRC_X2; w.acc = ACC_ADD;
      end
      PC_W'(3): begin
        w.coef = COEF_B3; w.src = SRC_X3; w.acc = ACC_ADD;
      end
      PC_W'(4): begin
        w.coef = COEF_A1; w.src = SRC_Y1L; w.acc = ACC_ADD;
        w.seq = SEQ_SKIP_FB; w.target = PC_FINISH;
      end
      PC_W'(5): begin
        w.coef = COEF_A1; w.src = SRC_Y1H; w.tmp = TMP_LOAD;
      end
      PC_W'(6): begin
        w.coef = COEF_A2; w.src = SRC_Y2L; w.tmp = TMP_ADD_HI;
      end
      PC_W'(7): begin
        w.coef = COEF_A2; w.src = SRC_Y2H; w.acc = ACC_SUB; w.tmp = TMP_LOAD;
      end
      PC_W'(8): begin
        w.coef = COEF_A3; w.src = SRC_Y3L; w.tmp = TMP_ADD_HI;
      end
      PC_W'(9): begin
        w.coef = COEF_A3; w.src = SRC_Y3H; w.acc = ACC_SUB; w.tmp = TMP_LOAD;
      end
      PC_W'(10): begin
        w.tmp = TMP_ADD_HI;
      end
      PC_W'(11): begin
        w.acc = ACC_SUB;
      end
      default: begin
        w.seq = SEQ_FINISH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/iirdf_cfg.sv
`default_nettype none

module iirdf_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [iirdf_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [iirdf_pkg::DATA_W-1:0]   pwdata,
  output logic      [iirdf_pkg::DATA_W-1:0]   prdata,
  output logic                                pready,
  output iirdf_pkg::cfg_t                     cfg_o
);

  iirdf_pkg::cfg_t  cfg_q, cfg_d;
  iirdf_pkg::reg_e  idx;
  logic             wr_en;
  logic [iirdf_pkg::COEF_W-1:0] wcoef;

  assign idx    = iirdf_pkg::reg_e'(paddr[iirdf_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wcoef  = pwdata[iirdf_pkg::COEF_W-1:0];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        iirdf_pkg::REG_B0:       cfg_d.b[0]  = wcoef;
        iirdf_pkg::REG_B1:       cfg_d.b[1]  = wcoef;
        iirdf_pkg::REG_B2:       cfg_d.b[2]  = wcoef;
        iirdf_pkg::REG_B3:       cfg_d.b[3]  = wcoef;
        iirdf_pkg::REG_A1:       cfg_d.a[0]  = wcoef;
        iirdf_pkg::REG_A2:       cfg_d.a[1]  = wcoef;
        iirdf_pkg::REG_A3:       cfg_d.a[2]  = wcoef;
        iirdf_pkg::REG_FEEDBACK: cfg_d.fb_on = pwdata[0];
        default:                 cfg_d       = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      iirdf_pkg::REG_B0:       prdata = iirdf_pkg::DATA_W'($signed(cfg_q.b[0]));
      iirdf_pkg::REG_B1:       prdata = iirdf_pkg::DATA_W'($signed(cfg_q.b[1]));
      iirdf_pkg::REG_B2:       prdata = iirdf_pkg::DATA_W'($signed(cfg_q.b[2]));
      iirdf_pkg::REG_B3:       prdata = iirdf_pkg::DATA_W'($signed(cfg_q.b[3]));
      iirdf_pkg::REG_A1:       prdata = iirdf_pkg::DATA_W'($signed(cfg_q.a[0]));
      iirdf_pkg::REG_A2:       prdata = iirdf_pkg::DATA_W'($signed(cfg_q.a[1]));
      iirdf_pkg::REG_A3:       prdata = iirdf_pkg::DATA_W'($signed(cfg_q.a[2]));
      iirdf_pkg::REG_FEEDBACK: prdata = iirdf_pkg::DATA_W'(cfg_q.fb_on);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{b: (iirdf_pkg::TAPS * iirdf_pkg::COEF_W)'(1048576), a: '0,
                 fb_on: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/iirdf_seq.sv
`default_nettype none

module iirdf_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          fb_on_i,
  input  wire logic          out_free_i,
  output iirdf_pkg::ctrl_t   ctrl_o
);

  logic                          busy_q, busy_d;
  logic [iirdf_pkg::PC_W-1:0]    pc_q, pc_d;
  iirdf_pkg::ucw_t               uw;
  logic                          finish_ok;
  logic                          accept;

  assign uw         = iirdf_pkg::ucode(pc_q);
  assign finish_ok  = busy_q && (uw.seq == iirdf_pkg::SEQ_FINISH) && out_free_i;
  assign in_stall_o = busy_q && !finish_ok;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (busy_q) begin
      case (uw.seq)
        iirdf_pkg::SEQ_NEXT: begin
          pc_d = pc_q + iirdf_pkg::PC_W'(1);
        end
        iirdf_pkg::SEQ_SKIP_FB: begin
          pc_d = fb_on_i ? pc_q + iirdf_pkg::PC_W'(1) : uw.target;
        end
        iirdf_pkg::SEQ_FINISH: begin
          if (out_free_i) begin
            busy_d = 1'b0;
            pc_d   = '0;
          end
        end
        default: begin
          busy_d = 1'b0;
          pc_d   = '0;
        end
      endcase
    end
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end
  end

  always_comb begin
    ctrl_o.load   = accept;
    ctrl_o.run    = busy_q;
    ctrl_o.commit = finish_ok;
    ctrl_o.uw     = uw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= iirdf_pkg::PC_LAST))
    else $error("step counter ran past the program");

  a_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pc_q == '0))
    else $error("step counter not parked while idle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && (pc_q == '0)))
    else $error("accepted beat did not start the program");

  a_commit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_ok |=> (!busy_q || (pc_q == '0)))
    else $error("program did not end after commit");

endmodule

`default_nettype wire

FILE: hw/rtl/iirdf_dp.sv
`default_nettype none

module iirdf_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire iirdf_pkg::ctrl_t                   ctrl_i,
  input  wire iirdf_pkg::cfg_t                    cfg_i,
  input  wire logic [iirdf_pkg::SAMPLE_W-1:0]     sample_in_i,
  input  wire logic                               block_start_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    out_free_o,
  output logic      [iirdf_pkg::SAMPLE_W-1:0]     sample_out_o,
  output logic                                    clipped_o
);

  localparam int unsigned ACC_W   = iirdf_pkg::ACC_W;
  localparam int unsigned TMP_W   = iirdf_pkg::TMP_W;
  localparam int unsigned SMP_W   = iirdf_pkg::SAMPLE_W;
  localparam int unsigned YH_W    = iirdf_pkg::YHIST_W;
  localparam int unsigned YL_W    = iirdf_pkg::YLO_W;
  localparam int unsigned OPND_W  = iirdf_pkg::OPND_W;
  localparam int unsigned TSH_W   = TMP_W - 12;
  localparam int unsigned HTR_W   = ACC_W - 8;
  localparam int unsigned YTR_W   = ACC_W - 20;

  logic [SMP_W-1:0]                                 x_q;
  logic [iirdf_pkg::HIST_DEPTH-1:0][SMP_W-1:0]      xh_q;
  logic [iirdf_pkg::HIST_DEPTH-1:0][YH_W-1:0]       yh_q;
  logic signed [iirdf_pkg::PROD_W-1:0]              prod_q;
  logic signed [ACC_W-1:0]                          acc_q, acc_d;
  logic signed [TMP_W-1:0]                          tmp_q, tmp_d;
  logic [SMP_W-1:0]                                 out_q;
  logic                                             clip_q;
  logic                                             out_valid_q;

  logic signed [iirdf_pkg::COEF_W-1:0]  coef_m;
  logic [1:0]                           tap;
  logic signed [OPND_W-1:0]             opnd;
  logic signed [TSH_W-1:0]              tsh;
  logic                                 tcorr;
  logic signed [HTR_W-1:0]              h_tr;
  logic signed [YTR_W-1:0]              y_tr;
  logic [YH_W-1:0]                      h_sat;
  logic [SMP_W-1:0]                     y_sat;
  logic                                 y_clip;

  always_comb begin
    case (ctrl_i.uw.coef)
      iirdf_pkg::COEF_B0: begin coef_m = cfg_i.b[0]; tap = 2'd0; end
      iirdf_pkg::COEF_B1: begin coef_m = cfg_i.b[1]; tap = 2'd1; end
      iirdf_pkg::COEF_B2: begin coef_m = cfg_i.b[2]; tap = 2'd2; end
      iirdf_pkg::COEF_B3: begin coef_m = cfg_i.b[3]; tap = 2'd3; end
      iirdf_pkg::COEF_A1: begin coef_m = cfg_i.a[0]; tap = 2'd1; end
      iirdf_pkg::COEF_A2: begin coef_m = cfg_i.a[1]; tap = 2'd2; end
      iirdf_pkg::COEF_A3: begin coef_m = cfg_i.a[2]; tap = 2'd3; end
      default:            begin coef_m = '0;         tap = 2'd0; end
    endcase
    if (32'(tap) >= iirdf_pkg::TAPS) begin
      coef_m = '0;
    end
  end

  always_comb begin
    case (ctrl_i.uw.src)
      iirdf_pkg::SRC_X:   opnd = OPND_W'($signed(x_q));
      iirdf_pkg::SRC_X1:  opnd = OPND_W'($signed(xh_q[0]));
      iirdf_pkg::SRC_X2:  opnd = OPND_W'($signed(xh_q[1]));
      iirdf_pkg::SRC_X3:  opnd = OPND_W'($signed(xh_q[2]));
      iirdf_pkg::SRC_Y1L: opnd = $signed({(OPND_W-YL_W)'(0), yh_q[0][YL_W-1:0]});
      iirdf_pkg::SRC_Y1H: opnd = OPND_W'($signed(yh_q[0][YH_W-1:YL_W]));
      iirdf_pkg::SRC_Y2L: opnd = $signed({(OPND_W-YL_W)'(0), yh_q[1][YL_W-1:0]});
      iirdf_pkg::SRC_Y2H: opnd = OPND_W'($signed(yh_q[1][YH_W-1:YL_W]));
      iirdf_pkg::SRC_Y3L: opnd = $signed({(OPND_W-YL_W)'(0), yh_q[2][YL_W-1:0]});
      iirdf_pkg::SRC_Y3H: opnd = OPND_W'($signed(yh_q[2][YH_W-1:YL_W]));
      default:            opnd = '0;
    endcase
  end

  assign tsh   = $signed(tmp_q[TMP_W-1:12]);
  assign tcorr = tmp_q[TMP_W-1] && (|tmp_q[11:0]);

  always_comb begin
    acc_d = acc_q;
    tmp_d = tmp_q;
    if (ctrl_i.run) begin
      case (ctrl_i.uw.acc)
        iirdf_pkg::ACC_LOAD: acc_d = ACC_W'(prod_q);
        iirdf_pkg::ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
        iirdf_pkg::ACC_SUB:  acc_d = acc_q + ~ACC_W'(tsh) + ACC_W'(!tcorr);
        default:             acc_d = acc_q;
      endcase
      case (ctrl_i.uw.tmp)
        iirdf_pkg::TMP_LOAD:   tmp_d = TMP_W'(prod_q);
        iirdf_pkg::TMP_ADD_HI: tmp_d = tmp_q + (TMP_W'(prod_q) <<< YL_W);
        default:               tmp_d = tmp_q;
      endcase
    end
  end

  assign h_tr = $signed(acc_q[ACC_W-1:8])
              + $signed({1'b0, acc_q[ACC_W-1] && (|acc_q[7:0])});
  assign y_tr = $signed(acc_q[ACC_W-1:20])
              + $signed({1'b0, acc_q[ACC_W-1] && (|acc_q[19:0])});

  always_comb begin
    if ((&h_tr[HTR_W-1:YH_W-1]) || !(|h_tr[HTR_W-1:YH_W-1])) begin
      h_sat = h_tr[YH_W-1:0];
    end else begin
      h_sat = {h_tr[HTR_W-1], {(YH_W-1){!h_tr[HTR_W-1]}}};
    end
    if ((&y_tr[YTR_W-1:SMP_W-1]) || !(|y_tr[YTR_W-1:SMP_W-1])) begin
      y_sat  = y_tr[SMP_W-1:0];
      y_clip = 1'b0;
    end else begin
      y_sat  = {y_tr[YTR_W-1], {(SMP_W-1){!y_tr[YTR_W-1]}}};
      y_clip = 1'b1;
    end
  end

  assign out_free_o   = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign clipped_o    = clip_q;

  always_ff @(posedge clk_i) begin
    prod_q <= coef_m * opnd;
    acc_q  <= acc_d;
    tmp_q  <= tmp_d;
    if (ctrl_i.load) begin
      x_q <= sample_in_i;
    end
    if (ctrl_i.commit) begin
      out_q  <= y_sat;
      clip_q <= y_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh_q        <= '0;
      yh_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.load && block_start_i) begin
        xh_q <= '0;
        yh_q <= '0;
      end else if (ctrl_i.commit) begin
        xh_q <= {xh_q[iirdf_pkg::HIST_DEPTH-2:0], x_q};
        yh_q <= {yh_q[iirdf_pkg::HIST_DEPTH-2:0], h_sat};
      end
      if (ctrl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_commit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit |-> !(out_valid_q && out_stall_i))
    else $error("result written over a beat still waiting");

  a_clip_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clip_q) |->
      ((out_q == {1'b0, {(SMP_W-1){1'b1}}}) || (out_q == {1'b1, {(SMP_W-1){1'b0}}})))
    else $error("clipped result not at a full-scale bound");

endmodule

`default_nettype wire

FILE: hw/rtl/iir_direct_form_filter.sv
// An accepted input beat runs the feedforward steps of the program and, with feedback
// on, the feedback steps, one step per cycle; the final step holds while output stalls.
// The single shared 24x25 multiplier serves every step; the next beat is taken in the
// cycle the result commits.
// Reset clears the sample histories and the output valid flag and restores the
// coefficient registers to b0 = 1.0, all others 0, with feedback on.
`default_nettype none

module iir_direct_form_filter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [iirdf_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [iirdf_pkg::DATA_W-1:0]       pwdata,
  output logic      [iirdf_pkg::DATA_W-1:0]       prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [iirdf_pkg::SAMPLE_W-1:0]     sample_in_i,
  input  wire logic                               block_start_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [iirdf_pkg::SAMPLE_W-1:0]     sample_out_o,
  output logic                                    clipped_o
);

  iirdf_pkg::cfg_t   cfg;
  iirdf_pkg::ctrl_t  ctrl;
  logic              out_free;

  iirdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iirdf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .fb_on_i    (cfg.fb_on),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  iirdf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg),
    .sample_in_i   (sample_in_i),
    .block_start_i (block_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_free_o    (out_free),
    .sample_out_o  (sample_out_o),
    .clipped_o     (clipped_o)
  );

endmodule

`default_nettype wire
